>>> hw/rtl/ddpi_pkg.sv
// ----------------------------------------------------------------------------
// ddpi_pkg
// Shared types, register map, datapath opcodes and the CORDIC angle table
// of the differential-drive pose integrator.
// ----------------------------------------------------------------------------
package ddpi_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int AtanCount          = 24;
	localparam int AddrWidth          = 4;

	localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;
	localparam logic signed [33:0] QuarterTurn   = 34'sd1073741824;
	localparam logic signed [33:0] HalfTurn      = 34'sd2147483648;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_TIME_STEP      = 2'd0;
	localparam logic [1:0] REG_NOISE_ENABLE   = 2'd1;
	localparam logic [1:0] REG_NOISE_FRACTION = 2'd2;
	localparam logic [1:0] REG_HEADING_GAIN   = 2'd3;

	localparam logic [15:0] TimeStepReset    = 16'd1092;
	localparam logic [23:0] HeadingGainReset = 24'd65536;

	typedef struct packed {
		logic        kind;
		logic [15:0] left_speed;
		logic [15:0] right_speed;
		logic [15:0] left_noise;
		logic [15:0] right_noise;
		logic [31:0] load_x;
		logic [31:0] load_y;
		logic [15:0] load_heading;
	} item_t;

	typedef struct packed {
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [15:0] heading;
	} pose_t;

	typedef struct packed {
		logic [15:0] time_step;
		logic        noise_enable;
		logic [15:0] noise_fraction;
		logic [23:0] heading_gain;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_LOAD,
		OP_TL,
		OP_TR,
		OP_FL,
		OP_NL,
		OP_FR,
		OP_NR,
		OP_TAKE_RAW,
		OP_TAKE_NZ,
		OP_GAIN,
		OP_HEAD,
		OP_ROT,
		OP_MX,
		OP_MY,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic last_step;
	} status_t;

	// atan(2^-i) in 2^-32 turn units
	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/ddpi_if.sv
// ----------------------------------------------------------------------------
// ddpi_if
// Valid/ready channels of the pose integrator: move items in, poses out.
// ----------------------------------------------------------------------------
interface ddpi_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] left_speed;
	logic [15:0] right_speed;
	logic [15:0] left_noise;
	logic [15:0] right_noise;
	logic [31:0] load_x;
	logic [31:0] load_y;
	logic [15:0] load_heading;

	modport source (output valid, kind, left_speed, right_speed, left_noise, right_noise,
		load_x, load_y, load_heading, input ready);
	modport sink (input valid, kind, left_speed, right_speed, left_noise, right_noise,
		load_x, load_y, load_heading, output ready);
endinterface

interface ddpi_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [15:0] heading;

	modport source (output valid, pos_x, pos_y, heading, input ready);
	modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

>>> hw/rtl/ddpi_regs.sv
// ----------------------------------------------------------------------------
// ddpi_regs
// APB configuration registers: time step, noise enable, noise fraction,
// heading gain.
// ----------------------------------------------------------------------------
module ddpi_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ddpi_pkg::AddrWidth-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output ddpi_pkg::cfg_t                  cfg
);
	ddpi_pkg::cfg_t cfg_q;
	logic [1:0]     idx;
	logic           wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step      <= ddpi_pkg::TimeStepReset;
			cfg_q.noise_enable   <= 1'b0;
			cfg_q.noise_fraction <= 16'd0;
			cfg_q.heading_gain   <= ddpi_pkg::HeadingGainReset;
		end else if (wr_en) begin
			unique case (idx)
				ddpi_pkg::REG_TIME_STEP:      cfg_q.time_step      <= pwdata[15:0];
				ddpi_pkg::REG_NOISE_ENABLE:   cfg_q.noise_enable   <= pwdata[0];
				ddpi_pkg::REG_NOISE_FRACTION: cfg_q.noise_fraction <= pwdata[15:0];
				ddpi_pkg::REG_HEADING_GAIN:   cfg_q.heading_gain   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			ddpi_pkg::REG_TIME_STEP:      prdata = {16'd0, cfg_q.time_step};
			ddpi_pkg::REG_NOISE_ENABLE:   prdata = {31'd0, cfg_q.noise_enable};
			ddpi_pkg::REG_NOISE_FRACTION: prdata = {16'd0, cfg_q.noise_fraction};
			ddpi_pkg::REG_HEADING_GAIN:   prdata = {8'd0, cfg_q.heading_gain};
			default:                      prdata = 32'd0;
		endcase
	end
endmodule

>>> hw/rtl/ddpi_ctrl.sv
// ----------------------------------------------------------------------------
// ddpi_ctrl
// Sequencer of the pose integrator: walks one item through the shared
// multiplier and the CORDIC iterations, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ddpi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_kind,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic               noise_enable,
	input  ddpi_pkg::status_t  status,
	output ddpi_pkg::cmd_t     cmd
);
	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_LOAD  = 15'b000000000000010,
		S_TL    = 15'b000000000000100,
		S_TR    = 15'b000000000001000,
		S_FL    = 15'b000000000010000,
		S_NL    = 15'b000000000100000,
		S_FR    = 15'b000000001000000,
		S_NR    = 15'b000000010000000,
		S_TAKE  = 15'b000000100000000,
		S_GAIN  = 15'b000001000000000,
		S_HEAD  = 15'b000010000000000,
		S_ROT   = 15'b000100000000000,
		S_MX    = 15'b001000000000000,
		S_MY    = 15'b010000000000000,
		S_FIN   = 15'b100000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   publish;

	assign slot_free = ~out_valid_q | out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign publish   = ((state_q == S_FIN) || (state_q == S_LOAD)) && slot_free;

	always_comb begin
		state_d = state_q;
		cmd.op  = ddpi_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = ddpi_pkg::OP_CAPTURE;
					state_d = in_kind ? S_LOAD : S_TL;
				end
			end
			S_LOAD: begin
				if (slot_free) begin
					cmd.op  = ddpi_pkg::OP_LOAD;
					state_d = S_IDLE;
				end
			end
			S_TL: begin
				cmd.op  = ddpi_pkg::OP_TL;
				state_d = S_TR;
			end
			S_TR: begin
				cmd.op  = ddpi_pkg::OP_TR;
				state_d = noise_enable ? S_FL : S_TAKE;
			end
			S_FL: begin
				cmd.op  = ddpi_pkg::OP_FL;
				state_d = S_NL;
			end
			S_NL: begin
				cmd.op  = ddpi_pkg::OP_NL;
				state_d = S_FR;
			end
			S_FR: begin
				cmd.op  = ddpi_pkg::OP_FR;
				state_d = S_NR;
			end
			S_NR: begin
				cmd.op  = ddpi_pkg::OP_NR;
				state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd.op  = noise_enable ? ddpi_pkg::OP_TAKE_NZ : ddpi_pkg::OP_TAKE_RAW;
				state_d = S_GAIN;
			end
			S_GAIN: begin
				cmd.op  = ddpi_pkg::OP_GAIN;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.op  = ddpi_pkg::OP_HEAD;
				state_d = S_ROT;
			end
			S_ROT: begin
				cmd.op = ddpi_pkg::OP_ROT;
				if (status.last_step) begin
					state_d = S_MX;
				end
			end
			S_MX: begin
				cmd.op  = ddpi_pkg::OP_MX;
				state_d = S_MY;
			end
			S_MY: begin
				cmd.op  = ddpi_pkg::OP_MY;
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output slot can take the new pose
				if (slot_free) begin
					cmd.op  = ddpi_pkg::OP_FIN;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

>>> hw/rtl/ddpi_dp.sv
// ----------------------------------------------------------------------------
// ddpi_dp
// Datapath of the pose integrator: item register, one shared 35x35
// multiplier with a product register, CORDIC rotator and pose registers.
// ----------------------------------------------------------------------------
module ddpi_dp #(
	parameter int CORDIC_STEPS = ddpi_pkg::CordicStepsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ddpi_pkg::cmd_t     cmd,
	output ddpi_pkg::status_t  status,
	input  ddpi_pkg::item_t    item,
	input  ddpi_pkg::cfg_t     cfg,
	output ddpi_pkg::pose_t    pose
);
	localparam int Steps = (CORDIC_STEPS > ddpi_pkg::AtanCount) ?
		ddpi_pkg::AtanCount : CORDIC_STEPS;

	ddpi_pkg::item_t     item_q;
	ddpi_pkg::pose_t     out_q;
	logic signed [69:0]  p_q;
	logic signed [34:0]  tl_q, tr_q, lin_q;
	logic signed [31:0]  x_q, y_q;
	logic [15:0]         hd_q;
	logic signed [33:0]  cx_q, cy_q, cz_q;
	logic                flip_q;
	logic [4:0]          i_q;

	logic signed [34:0]  ma, mb, fac, nz, diff;
	logic signed [69:0]  prod, rnd;
	logic signed [59:0]  hsum;
	logic [15:0]         hnew;
	logic signed [33:0]  ang, dx, dy, at, cfin, sfin;
	logic signed [33:0]  sum_pos;
	logic signed [31:0]  delta, pos_sel, pos_new;
	logic signed [35:0]  lin_sum;
	logic                mul_en;

	assign status.last_step = (i_q == 5'(Steps - 1));
	assign pose = out_q;

	assign fac     = 35'sd2147483648 + p_q[34:0];
	assign nz      = p_q[65:31];
	assign diff    = tr_q - tl_q;
	assign lin_sum = 36'(tl_q) + 36'(tr_q);
	assign cfin    = flip_q ? -cx_q : cx_q;
	assign sfin    = flip_q ? -cy_q : cy_q;

	// shared multiplier operands
	always_comb begin
		ma     = '0;
		mb     = '0;
		mul_en = 1'b1;
		case (cmd.op)
			ddpi_pkg::OP_TL: begin
				ma = 35'($signed(item_q.left_speed));
				mb = {19'd0, cfg.time_step};
			end
			ddpi_pkg::OP_TR: begin
				ma = 35'($signed(item_q.right_speed));
				mb = {19'd0, cfg.time_step};
			end
			ddpi_pkg::OP_FL: begin
				ma = 35'($signed(item_q.left_noise));
				mb = {19'd0, cfg.noise_fraction};
			end
			ddpi_pkg::OP_FR: begin
				ma = 35'($signed(item_q.right_noise));
				mb = {19'd0, cfg.noise_fraction};
			end
			ddpi_pkg::OP_NL: begin
				ma = tl_q;
				mb = fac;
			end
			ddpi_pkg::OP_NR: begin
				ma = tr_q;
				mb = fac;
			end
			ddpi_pkg::OP_GAIN: begin
				ma = diff;
				mb = {11'd0, cfg.heading_gain};
			end
			ddpi_pkg::OP_MX: begin
				ma = lin_q;
				mb = 35'(cfin);
			end
			ddpi_pkg::OP_MY: begin
				ma = lin_q;
				mb = 35'(sfin);
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign prod = ma * mb;

	// heading update with round half up, then fold into the right half plane
	assign hsum = p_q[59:0] + (60'sd1 <<< 39);
	assign hnew = hd_q + hsum[55:40];

	always_comb begin
		ang = 34'($signed({hnew, 16'h0000}));
		if (ang > ddpi_pkg::QuarterTurn) begin
			ang = ang - ddpi_pkg::HalfTurn;
		end else if (ang < -ddpi_pkg::QuarterTurn) begin
			ang = ang + ddpi_pkg::HalfTurn;
		end
	end

	assign dx = cy_q >>> i_q;
	assign dy = cx_q >>> i_q;
	assign at = 34'(ddpi_pkg::atan_turn(i_q));

	// position advance with round half up and saturation
	assign rnd     = p_q + (70'sd1 <<< 37);
	assign delta   = rnd[69:38];
	assign pos_sel = (cmd.op == ddpi_pkg::OP_MY) ? x_q : y_q;
	assign sum_pos = 34'(pos_sel) + 34'(delta);
	always_comb begin
		if (sum_pos > 34'sd2147483647) begin
			pos_new = 32'sh7FFFFFFF;
		end else if (sum_pos < -34'sd2147483648) begin
			pos_new = 32'sh80000000;
		end else begin
			pos_new = sum_pos[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q  <= '0;
			y_q  <= '0;
			hd_q <= '0;
		end else begin
			case (cmd.op)
				ddpi_pkg::OP_LOAD: begin
					x_q  <= item_q.load_x;
					y_q  <= item_q.load_y;
					hd_q <= item_q.load_heading;
				end
				ddpi_pkg::OP_HEAD: hd_q <= hnew;
				ddpi_pkg::OP_MY:   x_q  <= pos_new;
				ddpi_pkg::OP_FIN:  y_q  <= pos_new;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			p_q <= prod;
		end
		case (cmd.op)
			ddpi_pkg::OP_CAPTURE: item_q <= item;
			ddpi_pkg::OP_LOAD: begin
				out_q.pos_x   <= item_q.load_x;
				out_q.pos_y   <= item_q.load_y;
				out_q.heading <= item_q.load_heading;
			end
			ddpi_pkg::OP_TR:      tl_q <= p_q[34:0];
			ddpi_pkg::OP_FL:      tr_q <= p_q[34:0];
			ddpi_pkg::OP_FR:      tl_q <= nz;
			ddpi_pkg::OP_TAKE_RAW: tr_q <= p_q[34:0];
			ddpi_pkg::OP_TAKE_NZ:  tr_q <= nz;
			ddpi_pkg::OP_GAIN:    lin_q <= lin_sum[35:1];
			ddpi_pkg::OP_HEAD: begin
				cx_q   <= ddpi_pkg::CordicGainQ30;
				cy_q   <= '0;
				cz_q   <= ang;
				flip_q <= (ang != 34'($signed({hnew, 16'h0000})));
				i_q    <= '0;
			end
			ddpi_pkg::OP_ROT: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - at;
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + at;
				end
				i_q <= i_q + 5'd1;
			end
			ddpi_pkg::OP_FIN: begin
				out_q.pos_x   <= x_q;
				out_q.pos_y   <= pos_new;
				out_q.heading <= hd_q;
			end
			default: ;
		endcase
	end
endmodule

>>> hw/rtl/diff_drive_pose_integrator.sv
// Sequence: a move item runs through the time-step products, the noise products
// (noise on only), heading gain and update, CORDIC iterations and the two position
// products; a pose load is published directly. One item at a time, set by the
// shared multiplier and iterative CORDIC rotator; next item taken after a result.
// Reset (arst_n low, asynchronous): pose zero, registers to their defaults.
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator
// Dead-reckoning pose integrator for a two-wheel robot in fixed point.
// ----------------------------------------------------------------------------
module diff_drive_pose_integrator #(
	parameter int CORDIC_STEPS = ddpi_pkg::CordicStepsDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	ddpi_in_if.sink                        move_in,
	ddpi_out_if.source                     pose_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ddpi_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	ddpi_pkg::cfg_t    cfg;
	ddpi_pkg::cmd_t    cmd;
	ddpi_pkg::status_t status;
	ddpi_pkg::item_t   item;
	ddpi_pkg::pose_t   pose;

	assign item.kind         = move_in.kind;
	assign item.left_speed   = move_in.left_speed;
	assign item.right_speed  = move_in.right_speed;
	assign item.left_noise   = move_in.left_noise;
	assign item.right_noise  = move_in.right_noise;
	assign item.load_x       = move_in.load_x;
	assign item.load_y       = move_in.load_y;
	assign item.load_heading = move_in.load_heading;

	assign pose_out.pos_x   = pose.pos_x;
	assign pose_out.pos_y   = pose.pos_y;
	assign pose_out.heading = pose.heading;

	ddpi_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ddpi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (move_in.valid),
		.in_kind      (move_in.kind),
		.in_ready     (move_in.ready),
		.out_valid    (pose_out.valid),
		.out_ready    (pose_out.ready),
		.noise_enable (cfg.noise_enable),
		.status       (status),
		.cmd          (cmd)
	);

	ddpi_dp #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.cfg    (cfg),
		.pose   (pose)
	);
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pose integrator: random and directed move and
// pose-load items, an own fixed-point pose predictor, APB register writes
// between phases and random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CordicSteps = ddpi_pkg::CordicStepsDefault;
	localparam int WatchdogLimit = 4000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles = 300;
	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ddpi_pkg::AddrWidth-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ddpi_in_if  move_bus ();
	ddpi_out_if pose_bus ();

	diff_drive_pose_integrator #(.CORDIC_STEPS(CordicSteps)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.move_in (move_bus.sink),
		.pose_out(pose_bus.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ddpi_pkg::item_t move_queue[$];
	ddpi_pkg::pose_t pose_queue[$];
	int    errors;
	int    send_idle_pct;
	int    recv_stall_pct;
	int    hold_req;
	int    hold_served;
	int    hold_left;
	int    idle_cycles;

	// predictor state and register copy
	ddpi_pkg::cfg_t cfg;
	logic [31:0] pred_x;
	logic [31:0] pred_y;
	logic [15:0] pred_heading;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint apply_noise(longint travel, logic [15:0] noise);
		longint factor;
		factor = 64'sd2147483648 + longint'($signed(noise)) * longint'(cfg.noise_fraction);
		return (travel * factor) >>> 31;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic ddpi_pkg::pose_t advance_pose(ddpi_pkg::item_t it);
		longint left, right, linear, delta, ang, cx, cy, z, dx, dy;
		logic   flip;
		ddpi_pkg::pose_t p;
		if (it.kind == KIND_LOAD) begin
			pred_x = it.load_x;
			pred_y = it.load_y;
			pred_heading = it.load_heading;
		end else begin
			left = longint'($signed(it.left_speed)) * longint'(cfg.time_step);
			right = longint'($signed(it.right_speed)) * longint'(cfg.time_step);
			if (cfg.noise_enable) begin
				left = apply_noise(left, it.left_noise);
				right = apply_noise(right, it.right_noise);
			end
			linear = (left + right) >>> 1;
			delta = ((right - left) * longint'(cfg.heading_gain) + (64'sd1 <<< 39)) >>> 40;
			pred_heading = pred_heading + delta[15:0];
			// fold the angle into the right half plane, negate afterwards
			ang = longint'(pred_heading) <<< 16;
			if (ang >= ddpi_pkg::HalfTurn)
				ang -= 2 * longint'(ddpi_pkg::HalfTurn);
			flip = 1'b0;
			if (ang > ddpi_pkg::QuarterTurn) begin
				ang -= ddpi_pkg::HalfTurn;
				flip = 1'b1;
			end else if (ang < -ddpi_pkg::QuarterTurn) begin
				ang += ddpi_pkg::HalfTurn;
				flip = 1'b1;
			end
			cx = ddpi_pkg::CordicGainQ30;
			cy = 0;
			z = ang;
			for (int i = 0; i < (CordicSteps > ddpi_pkg::AtanCount ?
				ddpi_pkg::AtanCount : CordicSteps); i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (z >= 0) begin
					cx -= dx;
					cy += dy;
					z -= longint'(ddpi_pkg::atan_turn(i[4:0]));
				end else begin
					cx += dx;
					cy -= dy;
					z += longint'(ddpi_pkg::atan_turn(i[4:0]));
				end
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			pred_x = 32'(clamp32(longint'($signed(pred_x))
				+ ((linear * cx + (64'sd1 <<< 37)) >>> 38)));
			pred_y = 32'(clamp32(longint'($signed(pred_y))
				+ ((linear * cy + (64'sd1 <<< 37)) >>> 38)));
		end
		p.pos_x = pred_x;
		p.pos_y = pred_y;
		p.heading = pred_heading;
		return p;
	endfunction

	function automatic ddpi_pkg::item_t move_item(logic [15:0] ls, logic [15:0] rs,
		logic [15:0] ln, logic [15:0] rn);
		ddpi_pkg::item_t it;
		it.kind = KIND_MOVE;
		it.left_speed = ls;
		it.right_speed = rs;
		it.left_noise = ln;
		it.right_noise = rn;
		it.load_x = $urandom;
		it.load_y = $urandom;
		it.load_heading = 16'($urandom);
		return it;
	endfunction

	function automatic ddpi_pkg::item_t load_item(logic [31:0] x, logic [31:0] y,
		logic [15:0] h);
		ddpi_pkg::item_t it;
		it = move_item(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		it.kind = KIND_LOAD;
		it.load_x = x;
		it.load_y = y;
		it.load_heading = h;
		return it;
	endfunction

	function automatic ddpi_pkg::item_t random_item();
		logic [15:0] ls, rs;
		logic [31:0] x, y;
		if ($urandom_range(99) < 15) begin
			x = $urandom;
			y = $urandom;
			// park near the rails now and then so moves hit saturation
			if ($urandom_range(3) == 0)
				x = {x[31], {7{~x[31]}}, x[23:0]};
			if ($urandom_range(3) == 0)
				y = {y[31], {7{~y[31]}}, y[23:0]};
			return load_item(x, y, 16'($urandom));
		end
		ls = 16'($urandom);
		rs = 16'($urandom);
		if ($urandom_range(2) == 0) begin
			ls = 16'($urandom_range(1023) - 512);
			rs = 16'(ls + $urandom_range(63) - 32);
		end
		return move_item(ls, rs, 16'($urandom), 16'($urandom));
	endfunction

	task automatic note_error(string msg);
		if (errors < 10)
			$display("%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ddpi_pkg::AddrWidth'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ddpi_pkg::REG_TIME_STEP:      cfg.time_step = value[15:0];
			ddpi_pkg::REG_NOISE_ENABLE:   cfg.noise_enable = value[0];
			ddpi_pkg::REG_NOISE_FRACTION: cfg.noise_fraction = value[15:0];
			ddpi_pkg::REG_HEADING_GAIN:   cfg.heading_gain = value[23:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] ts, logic ne, logic [15:0] nf, logic [23:0] hg);
		reg_write(ddpi_pkg::REG_TIME_STEP, {16'd0, ts});
		reg_write(ddpi_pkg::REG_NOISE_ENABLE, {31'd0, ne});
		reg_write(ddpi_pkg::REG_NOISE_FRACTION, {16'd0, nf});
		reg_write(ddpi_pkg::REG_HEADING_GAIN, {8'd0, hg});
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (move_queue.size() != 0 || move_bus.valid || pose_queue.size() != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// feed the input channel
	always @(posedge clk) begin
		ddpi_pkg::item_t it;
		if (arst_n && (!move_bus.valid || move_bus.ready)) begin
			if (move_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				it = move_queue.pop_front();
				move_bus.valid <= 1'b1;
				move_bus.kind <= it.kind;
				move_bus.left_speed <= it.left_speed;
				move_bus.right_speed <= it.right_speed;
				move_bus.left_noise <= it.left_noise;
				move_bus.right_noise <= it.right_noise;
				move_bus.load_x <= it.load_x;
				move_bus.load_y <= it.load_y;
				move_bus.load_heading <= it.load_heading;
			end else begin
				move_bus.valid <= 1'b0;
			end
		end
	end

	// predict on every accepted item
	always @(posedge clk) begin
		ddpi_pkg::item_t it;
		if (arst_n && move_bus.valid && move_bus.ready) begin
			it.kind = move_bus.kind;
			it.left_speed = move_bus.left_speed;
			it.right_speed = move_bus.right_speed;
			it.left_noise = move_bus.left_noise;
			it.right_noise = move_bus.right_noise;
			it.load_x = move_bus.load_x;
			it.load_y = move_bus.load_y;
			it.load_heading = move_bus.load_heading;
			pose_queue.push_back(advance_pose(it));
		end
	end

	// check poses, drive ready
	always @(posedge clk) begin
		ddpi_pkg::pose_t want;
		if (arst_n) begin
			if (pose_bus.valid && pose_bus.ready) begin
				if (pose_queue.size() == 0) begin
					note_error($sformatf("unexpected pose x=%h y=%h h=%h",
						pose_bus.pos_x, pose_bus.pos_y, pose_bus.heading));
				end else begin
					want = pose_queue.pop_front();
					if (pose_bus.pos_x !== want.pos_x)
						note_error($sformatf("pos_x exp %h got %h", want.pos_x, pose_bus.pos_x));
					if (pose_bus.pos_y !== want.pos_y)
						note_error($sformatf("pos_y exp %h got %h", want.pos_y, pose_bus.pos_y));
					if (pose_bus.heading !== want.heading)
						note_error($sformatf("heading exp %h got %h",
							want.heading, pose_bus.heading));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				pose_bus.ready <= 1'b0;
			end else if (hold_req != hold_served) begin
				hold_served <= hold_req;
				hold_left <= HoldCycles;
				pose_bus.ready <= 1'b0;
			end else begin
				pose_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((move_bus.valid && move_bus.ready) || (pose_bus.valid && pose_bus.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		move_bus.valid = 1'b0;
		move_bus.kind = KIND_MOVE;
		move_bus.left_speed = '0;
		move_bus.right_speed = '0;
		move_bus.left_noise = '0;
		move_bus.right_noise = '0;
		move_bus.load_x = '0;
		move_bus.load_y = '0;
		move_bus.load_heading = '0;
		pose_bus.ready = 1'b0;
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		hold_served = 0;
		hold_left = 0;
		idle_cycles = 0;
		cfg.time_step = ddpi_pkg::TimeStepReset;
		cfg.noise_enable = 1'b0;
		cfg.noise_fraction = '0;
		cfg.heading_gain = ddpi_pkg::HeadingGainReset;
		pred_x = '0;
		pred_y = '0;
		pred_heading = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: straight runs both ways and spins
		move_queue.push_back(move_item(16'h0000, 16'h0000, 16'h7fff, 16'h8000));
		move_queue.push_back(move_item(16'h7fff, 16'h7fff, 16'h0000, 16'h0000));
		move_queue.push_back(move_item(16'h8000, 16'h8000, 16'h0000, 16'h0000));
		move_queue.push_back(move_item(16'h8000, 16'h7fff, 16'h0000, 16'h0000));
		move_queue.push_back(move_item(16'h7fff, 16'h8000, 16'hffff, 16'hffff));
		wait_drained();

		// extreme registers: full noise, saturation, quadrant boundaries
		set_config(16'hffff, 1'b1, 16'hffff, 24'hffffff);
		move_queue.push_back(move_item(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff));
		move_queue.push_back(move_item(16'h8000, 16'h8000, 16'h7fff, 16'h8000));
		move_queue.push_back(load_item(32'h7fff0000, 32'h80010000, 16'h0000));
		move_queue.push_back(move_item(16'h7fff, 16'h7fff, 16'h0000, 16'h0000));
		move_queue.push_back(load_item(32'h7fff0000, 32'h80010000, 16'hc000));
		move_queue.push_back(move_item(16'h7fff, 16'h7fff, 16'h0000, 16'h0000));
		move_queue.push_back(load_item(32'h80000000, 32'h7fffffff, 16'h8000));
		move_queue.push_back(move_item(16'h7fff, 16'h7fff, 16'h0000, 16'h0000));
		move_queue.push_back(load_item(32'h00000000, 32'h00000000, 16'h4000));
		move_queue.push_back(move_item(16'h0100, 16'h0100, 16'h0000, 16'h0000));
		move_queue.push_back(load_item(32'hffffffff, 32'h00000001, 16'hffff));
		move_queue.push_back(move_item(16'h0100, 16'h0100, 16'h0000, 16'h0000));
		wait_drained();

		// zero time step leaves the pose alone
		set_config(16'h0000, 1'b1, 16'h8000, 24'h123456);
		move_queue.push_back(move_item(16'h7fff, 16'h8000, 16'h7fff, 16'h8000));
		move_queue.push_back(move_item(16'h1234, 16'h4321, 16'h0000, 16'h0000));
		wait_drained();

		for (int c = 0; c < 4; c++) begin
			case (c)
				0: set_config(ddpi_pkg::TimeStepReset, 1'b0, 16'hffff,
					ddpi_pkg::HeadingGainReset);
				1: set_config(16'hffff, 1'b1, 16'hffff, 24'hffffff);
				2: set_config(16'h0001, 1'b1, 16'h0000, 24'h000000);
				default: set_config(16'($urandom_range(65535, 1)), 1'b1, 16'($urandom),
					24'($urandom));
			endcase
			for (int p = 0; p < 4; p++) begin
				case (p)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
					default: begin send_idle_pct = 9; recv_stall_pct = 9; end
				endcase
				for (int n = 0; n < 18; n++)
					move_queue.push_back(random_item());
				if (c == 1 && p == 0)
					hold_req++;
				// pause until all poses are back, then go on
				if (p == 2)
					wait_drained();
				for (int n = 0; n < 18; n++)
					move_queue.push_back(random_item());
				wait_drained();
			end
		end

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
